// ===== rtl/tndf_pkg.sv =====
package tndf_pkg;

    localparam int unsigned SQRT_STAGES = 32;
    localparam int unsigned ENERGY_LAT = 6;

    localparam logic [1:0] ERR_OK           = 2'd0;
    localparam logic [1:0] ERR_ZERO_CURRENT = 2'd1;
    localparam logic [1:0] ERR_ZERO_TWINE   = 2'd2;

    typedef struct packed {
        logic signed [31:0] current_x;
        logic signed [31:0] current_y;
        logic signed [31:0] current_z;
        logic signed [31:0] twine_x;
        logic signed [31:0] twine_y;
        logic signed [31:0] twine_z;
        logic [30:0]        element_factor;
    } drag_in_t;

    typedef struct packed {
        logic signed [31:0] normal_force_x;
        logic signed [31:0] normal_force_y;
        logic signed [31:0] normal_force_z;
        logic [1:0]         error_code;
    } drag_out_t;

    // carried alongside the square root
    typedef struct packed {
        logic             valid;
        logic [1:0]       err;
        logic [2:0]       vneg;
        logic [2:0][31:0] vmag;
        logic [2:0][31:0] u;
        logic [63:0]      su;
    } side_b_t;

    typedef struct packed {
        logic             valid;
        logic [1:0]       err;
        logic [2:0][31:0] u;
        logic [63:0]      su;
        logic [30:0]      e;
    } side_d_t;

    typedef struct packed {
        side_d_t    core;
        logic [2:0] vneg;
    } side_c_t;

    typedef struct packed {
        logic        valid;
        logic [1:0]  err;
        logic [30:0] e;
        logic [3:0]  sat;
        logic [2:0]  nneg;
    } side_f_t;

    function automatic logic [31:0] mag32(input logic [31:0] x);
        mag32 = x[31] ? 32'(-x) : x;
    endfunction

    // round to nearest with ties up, then clamp to 2^31-1
    function automatic logic [30:0] rnd_uclamp(input logic [63:0] x, input int unsigned fb);
        logic [63:0] r;
        r = (x >> fb) + ((x >> (fb - 1)) & 64'd1);
        rnd_uclamp = (r > 64'h7FFF_FFFF) ? 31'h7FFF_FFFF : r[30:0];
    endfunction

    // round to nearest, ties away from zero
    function automatic logic signed [63:0] rnd_signed(input logic signed [63:0] x,
                                                      input int unsigned fb);
        logic [63:0] m;
        m = x[63] ? 64'(-x) : 64'(x);
        m = (m + (64'd1 << (fb - 1))) >> fb;
        rnd_signed = x[63] ? -$signed(m) : $signed(m);
    endfunction

    function automatic logic signed [31:0] clamp_sym32(input logic signed [63:0] x);
        if (x > 64'sh7FFF_FFFF)
            clamp_sym32 = 32'sh7FFF_FFFF;
        else if (x < -64'sh7FFF_FFFF)
            clamp_sym32 = -32'sh7FFF_FFFF;
        else
            clamp_sym32 = x[31:0];
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
        if (x > 64'sh7FFF_FFFF)
            sat32 = 32'sh7FFF_FFFF;
        else if (x < -64'sh8000_0000)
            sat32 = 32'sh8000_0000;
        else
            sat32 = x[31:0];
    endfunction

endpackage

// ===== rtl/tndf_delay.sv =====
module tndf_delay #(
    parameter int unsigned W = 8,
    parameter int unsigned DEPTH = 1
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic [W-1:0] din,
    output logic [W-1:0] dout
);

    logic [W-1:0] pipe_reg [DEPTH];

    for (genvar k = 0; k < DEPTH; k++) begin : g_tap
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                pipe_reg[k] <= '0;
            else if (k == 0)
                pipe_reg[k] <= din;
            else
                pipe_reg[k] <= pipe_reg[(k == 0) ? 0 : k - 1];
        end
    end

    assign dout = pipe_reg[DEPTH-1];

endmodule

// ===== rtl/tndf_sqrt.sv =====
module tndf_sqrt (
    input  logic        clk,
    input  logic [63:0] radicand,
    output logic [31:0] root
);

    localparam int unsigned N = tndf_pkg::SQRT_STAGES;

    logic [63:0] x_reg   [N];
    logic [63:0] res_reg [N];

    // one result bit per stage
    for (genvar k = 0; k < N; k++) begin : g_stage
        localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
        logic [63:0] x_in;
        logic [63:0] res_in;
        logic [63:0] trial;
        logic        ge;

        if (k == 0) begin : g_first
            assign x_in   = radicand;
            assign res_in = '0;
        end else begin : g_rest
            assign x_in   = x_reg[k-1];
            assign res_in = res_reg[k-1];
        end

        assign trial = res_in + BIT;
        assign ge    = x_in >= trial;

        always_ff @(posedge clk)
        begin
            x_reg[k]   <= ge ? x_in - trial : x_in;
            res_reg[k] <= ge ? (res_in >> 1) + BIT : res_in >> 1;
        end
    end

    assign root = res_reg[N-1][31:0];

endmodule

// ===== rtl/tndf_divider.sv =====
module tndf_divider #(
    parameter int unsigned DW = 32,
    parameter int unsigned QW = 17
) (
    input  logic          clk,
    input  logic [DW-1:0] hi,
    input  logic [QW-1:0] lo,
    input  logic [DW-1:0] d,
    output logic [QW-1:0] q
);

    logic [DW-1:0] r_reg  [QW];
    logic [QW-1:0] lo_reg [QW];
    logic [DW-1:0] d_reg  [QW];
    logic [QW-1:0] q_reg  [QW];

    // restoring division, one quotient bit per stage; hi < d on entry
    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic [DW-1:0] r_in;
        logic [QW-1:0] lo_in;
        logic [DW-1:0] d_in;
        logic [QW-1:0] q_in;
        logic [DW:0]   trial;
        logic [DW:0]   diff;
        logic          ge;

        if (k == 0) begin : g_first
            assign r_in  = hi;
            assign lo_in = lo;
            assign d_in  = d;
            assign q_in  = '0;
        end else begin : g_rest
            assign r_in  = r_reg[k-1];
            assign lo_in = lo_reg[k-1];
            assign d_in  = d_reg[k-1];
            assign q_in  = q_reg[k-1];
        end

        assign trial = {r_in, lo_in[QW-1]};
        assign ge    = trial >= {1'b0, d_in};
        assign diff  = trial - {1'b0, d_in};

        always_ff @(posedge clk)
        begin
            r_reg[k]  <= ge ? diff[DW-1:0] : trial[DW-1:0];
            lo_reg[k] <= lo_in << 1;
            d_reg[k]  <= d_in;
            q_reg[k]  <= {q_in[QW-2:0], ge};
        end
    end

    assign q = q_reg[QW-1];

endmodule

// ===== rtl/tndf_energy.sv =====
module tndf_energy #(
    parameter int unsigned FRACTION_BITS = 16
) (
    input  logic        clk,
    input  logic [63:0] sv,
    input  logic [30:0] factor,
    input  logic [30:0] density,
    output logic [30:0] energy
);

    localparam int unsigned F = FRACTION_BITS;
    localparam logic [30:0] SIXTH = 31'(((64'd1 << F) + 64'd3) / 64'd6);

    logic [30:0] v2_reg;
    logic [30:0] v2_hold_reg;
    logic [61:0] p1_reg;
    logic [30:0] t1_reg;
    logic [61:0] p2_reg;
    logic [30:0] t2_reg;
    logic [61:0] p3_reg;
    logic [30:0] e_reg;

    // density*factor, times |V|^2, times one sixth, each rounded and clamped
    always_ff @(posedge clk)
    begin
        v2_reg      <= tndf_pkg::rnd_uclamp(sv, F);
        p1_reg      <= density * factor;
        t1_reg      <= tndf_pkg::rnd_uclamp(64'(p1_reg), F);
        v2_hold_reg <= v2_reg;
        p2_reg      <= t1_reg * v2_hold_reg;
        t2_reg      <= tndf_pkg::rnd_uclamp(64'(p2_reg), F);
        p3_reg      <= t2_reg * SIXTH;
        e_reg       <= tndf_pkg::rnd_uclamp(64'(p3_reg), F);
    end

    assign energy = e_reg;

endmodule

// ===== rtl/twine_normal_drag_force.sv =====
// channel   direction  handshake            payload
// request   in         start, busy          tndf_pkg::drag_in_t
// result    out        done (one cycle)     tndf_pkg::drag_out_t
// config    in         cfg_valid, cfg_ready cfg_data (water density)
//
// one beat enters per clock; busy stays low and cfg_ready stays high
// the pipeline runs through the 32-stage square root and the two
// bit-per-stage dividers
// rst_n clears the valid bits of every stage and loads the default density
// the receiver cannot stall, so nothing in the pipeline ever holds
module twine_normal_drag_force #(
    parameter int unsigned FRACTION_BITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  tndf_pkg::drag_in_t  request,
    output logic                done,
    output tndf_pkg::drag_out_t result,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [30:0]         cfg_data
);

    localparam int unsigned F = FRACTION_BITS;
    localparam logic [63:0] DENSITY_RAW = 64'd1025 << F;
    localparam logic [30:0] DENSITY_RESET =
        (DENSITY_RAW > 64'h7FFF_FFFF) ? 31'h7FFF_FFFF : DENSITY_RAW[30:0];
    localparam logic [F:0] ONE_Q = {1'b1, {F{1'b0}}};

    // ------------------------------------------------------------------
    // configuration
    // ------------------------------------------------------------------
    logic [30:0] density_reg;

    assign cfg_ready = 1'b1;
    assign busy      = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            density_reg <= DENSITY_RESET;
        else if (cfg_valid && cfg_ready)
            density_reg <= cfg_data;
    end

    // ------------------------------------------------------------------
    // stage 1..3: magnitudes, squares, exact sums, error code
    // ------------------------------------------------------------------
    logic [2:0][31:0] cur;
    logic [2:0][31:0] twn;

    assign cur[0] = request.current_x;
    assign cur[1] = request.current_y;
    assign cur[2] = request.current_z;
    assign twn[0] = request.twine_x;
    assign twn[1] = request.twine_y;
    assign twn[2] = request.twine_z;

    logic             s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic [2:0][31:0] s1_vmag_reg, s2_vmag_reg, s3_vmag_reg;
    logic [2:0][31:0] s1_umag_reg;
    logic [2:0][31:0] s1_u_reg, s2_u_reg, s3_u_reg;
    logic [2:0]       s1_vneg_reg, s2_vneg_reg, s3_vneg_reg;
    logic [30:0]      s1_fac_reg, s2_fac_reg, s3_fac_reg;
    logic [2:0][63:0] s2_vsq_reg, s2_usq_reg;
    logic [63:0]      s3_sv_reg, s3_su_reg;
    logic [1:0]       s3_err_reg;
    logic [63:0]      sv_sum, su_sum;

    assign sv_sum = s2_vsq_reg[0] + s2_vsq_reg[1] + s2_vsq_reg[2];
    assign su_sum = s2_usq_reg[0] + s2_usq_reg[1] + s2_usq_reg[2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= start && !busy;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            s1_vmag_reg[i] <= tndf_pkg::mag32(cur[i]);
            s1_umag_reg[i] <= tndf_pkg::mag32(twn[i]);
            s1_vneg_reg[i] <= cur[i][31];
            s1_u_reg[i]    <= twn[i];
            s2_vsq_reg[i]  <= 64'(s1_vmag_reg[i]) * 64'(s1_vmag_reg[i]);
            s2_usq_reg[i]  <= 64'(s1_umag_reg[i]) * 64'(s1_umag_reg[i]);
        end
        s1_fac_reg  <= request.element_factor;
        s2_vmag_reg <= s1_vmag_reg;
        s2_vneg_reg <= s1_vneg_reg;
        s2_u_reg    <= s1_u_reg;
        s2_fac_reg  <= s1_fac_reg;
        s3_vmag_reg <= s2_vmag_reg;
        s3_vneg_reg <= s2_vneg_reg;
        s3_u_reg    <= s2_u_reg;
        s3_fac_reg  <= s2_fac_reg;
        s3_sv_reg   <= sv_sum;
        s3_su_reg   <= su_sum;
        // current is checked before twine
        if (sv_sum == '0)
            s3_err_reg <= tndf_pkg::ERR_ZERO_CURRENT;
        else if (su_sum == '0)
            s3_err_reg <= tndf_pkg::ERR_ZERO_TWINE;
        else
            s3_err_reg <= tndf_pkg::ERR_OK;
    end

    // ------------------------------------------------------------------
    // |V| by square root, energy term alongside
    // ------------------------------------------------------------------
    tndf_pkg::side_b_t side_b_in, side_b_out;
    logic [31:0] magv;
    logic [30:0] e_early, e_aligned;

    assign side_b_in.valid = s3_valid_reg;
    assign side_b_in.err   = s3_err_reg;
    assign side_b_in.vneg  = s3_vneg_reg;
    assign side_b_in.vmag  = s3_vmag_reg;
    assign side_b_in.u     = s3_u_reg;
    assign side_b_in.su    = s3_su_reg;

    tndf_sqrt u_sqrt (
        .clk      (clk),
        .radicand (s3_sv_reg),
        .root     (magv)
    );

    tndf_delay #(
        .W     ($bits(tndf_pkg::side_b_t)),
        .DEPTH (tndf_pkg::SQRT_STAGES)
    ) u_side_b (
        .clk   (clk),
        .rst_n (rst_n),
        .din   (side_b_in),
        .dout  (side_b_out)
    );

    tndf_energy #(
        .FRACTION_BITS (F)
    ) u_energy (
        .clk     (clk),
        .sv      (s3_sv_reg),
        .factor  (s3_fac_reg),
        .density (density_reg),
        .energy  (e_early)
    );

    tndf_delay #(
        .W     (31),
        .DEPTH (tndf_pkg::SQRT_STAGES - tndf_pkg::ENERGY_LAT)
    ) u_energy_align (
        .clk   (clk),
        .rst_n (rst_n),
        .din   (e_early),
        .dout  (e_aligned)
    );

    // ------------------------------------------------------------------
    // unit current vector: rounded |V_i| / |V|
    // ------------------------------------------------------------------
    logic [2:0][63:0] vn_num;
    logic [2:0][31:0] c_hi_reg;
    logic [2:0][F:0]  c_lo_reg;
    logic [31:0]      c_magv_reg;
    logic [2:0][F:0]  vq;
    tndf_pkg::side_c_t side_c_in, side_c_out;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            vn_num[i] = (64'(side_b_out.vmag[i]) << F) + 64'(magv >> 1);
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            c_hi_reg[i] <= 32'(vn_num[i] >> (F + 1));
            c_lo_reg[i] <= vn_num[i][F:0];
        end
        c_magv_reg <= magv;
    end

    assign side_c_in.core.valid = side_b_out.valid;
    assign side_c_in.core.err   = side_b_out.err;
    assign side_c_in.core.u     = side_b_out.u;
    assign side_c_in.core.su    = side_b_out.su;
    assign side_c_in.core.e     = e_aligned;
    assign side_c_in.vneg       = side_b_out.vneg;

    for (genvar i = 0; i < 3; i++) begin : g_vn_div
        tndf_divider #(
            .DW (32),
            .QW (F + 1)
        ) u_div (
            .clk (clk),
            .hi  (c_hi_reg[i]),
            .lo  (c_lo_reg[i]),
            .d   (c_magv_reg),
            .q   (vq[i])
        );
    end

    tndf_delay #(
        .W     ($bits(tndf_pkg::side_c_t)),
        .DEPTH (F + 2)
    ) u_side_c (
        .clk   (clk),
        .rst_n (rst_n),
        .din   (side_c_in),
        .dout  (side_c_out)
    );

    logic signed [F+1:0] vn [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            vn[i] = side_c_out.vneg[i] ? -$signed({1'b0, vq[i]}) : $signed({1'b0, vq[i]});
    end

    // ------------------------------------------------------------------
    // W = Vn x u, rounded and clamped
    // ------------------------------------------------------------------
    tndf_pkg::side_d_t d1_side_reg, d2_side_reg, d3_side_reg;
    logic signed [F+33:0] d1_prod_reg [6];
    logic signed [63:0]   d2_diff_reg [3];
    logic signed [31:0]   d3_w_reg [3];
    logic signed [31:0]   cu [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            cu[i] = side_c_out.core.u[i];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d1_side_reg <= '0;
            d2_side_reg <= '0;
            d3_side_reg <= '0;
        end
        else
        begin
            d1_side_reg <= side_c_out.core;
            d2_side_reg <= d1_side_reg;
            d3_side_reg <= d2_side_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        d1_prod_reg[0] <= vn[1] * cu[2];
        d1_prod_reg[1] <= vn[2] * cu[1];
        d1_prod_reg[2] <= vn[2] * cu[0];
        d1_prod_reg[3] <= vn[0] * cu[2];
        d1_prod_reg[4] <= vn[0] * cu[1];
        d1_prod_reg[5] <= vn[1] * cu[0];
        for (int i = 0; i < 3; i++)
        begin
            d2_diff_reg[i] <= 64'(d1_prod_reg[2*i]) - 64'(d1_prod_reg[2*i+1]);
            d3_w_reg[i]    <= tndf_pkg::clamp_sym32(tndf_pkg::rnd_signed(d2_diff_reg[i], F));
        end
    end

    // ------------------------------------------------------------------
    // |W|^2 and num = u x W
    // ------------------------------------------------------------------
    logic             e1_valid_reg, e2_valid_reg;
    logic [1:0]       e1_err_reg, e2_err_reg;
    logic [63:0]      e1_su_reg, e2_su_reg;
    logic [30:0]      e1_e_reg, e2_e_reg;
    logic [2:0][63:0] e1_wsq_reg;
    logic signed [63:0] e1_prod_reg [6];
    logic [63:0]      e2_sw_reg;
    logic signed [63:0] e2_num_reg [3];
    logic signed [31:0] du [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            du[i] = d3_side_reg.u[i];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e1_valid_reg <= 1'b0;
            e2_valid_reg <= 1'b0;
        end
        else
        begin
            e1_valid_reg <= d3_side_reg.valid;
            e2_valid_reg <= e1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
            e1_wsq_reg[i] <= 64'(tndf_pkg::mag32(d3_w_reg[i]))
                           * 64'(tndf_pkg::mag32(d3_w_reg[i]));
        e1_prod_reg[0] <= du[1] * d3_w_reg[2];
        e1_prod_reg[1] <= du[2] * d3_w_reg[1];
        e1_prod_reg[2] <= du[2] * d3_w_reg[0];
        e1_prod_reg[3] <= du[0] * d3_w_reg[2];
        e1_prod_reg[4] <= du[0] * d3_w_reg[1];
        e1_prod_reg[5] <= du[1] * d3_w_reg[0];
        e1_err_reg <= d3_side_reg.err;
        e1_su_reg  <= d3_side_reg.su;
        e1_e_reg   <= d3_side_reg.e;
        e2_sw_reg  <= e1_wsq_reg[0] + e1_wsq_reg[1] + e1_wsq_reg[2];
        for (int i = 0; i < 3; i++)
            e2_num_reg[i] <= e1_prod_reg[2*i] - e1_prod_reg[2*i+1];
        e2_err_reg <= e1_err_reg;
        e2_su_reg  <= e1_su_reg;
        e2_e_reg   <= e1_e_reg;
    end

    // ------------------------------------------------------------------
    // sin2 = |W|^2/|u|^2 and m = num/|u|^2, each saturated at one
    // ------------------------------------------------------------------
    logic [3:0][63:0] ratio_a;
    logic [3:0][63:0] f_hi_reg;
    logic [63:0]      f_su_reg;
    tndf_pkg::side_f_t f_side_reg, side_f_out;
    logic [3:0][F-1:0] rq;

    always_comb
    begin
        ratio_a[0] = e2_sw_reg;
        for (int i = 0; i < 3; i++)
            ratio_a[i+1] = e2_num_reg[i][63] ? 64'(-e2_num_reg[i]) : 64'(e2_num_reg[i]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            f_side_reg <= '0;
        else
        begin
            f_side_reg.valid <= e2_valid_reg;
            for (int i = 0; i < 4; i++)
                f_side_reg.sat[i] <= ratio_a[i] >= e2_su_reg;
            for (int i = 0; i < 3; i++)
                f_side_reg.nneg[i] <= e2_num_reg[i][63];
            f_side_reg.err <= e2_err_reg;
            f_side_reg.e   <= e2_e_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 4; i++)
            f_hi_reg[i] <= (ratio_a[i] >= e2_su_reg) ? '0 : ratio_a[i];
        f_su_reg <= e2_su_reg;
    end

    for (genvar i = 0; i < 4; i++) begin : g_ratio_div
        tndf_divider #(
            .DW (64),
            .QW (F)
        ) u_div (
            .clk (clk),
            .hi  (f_hi_reg[i]),
            .lo  ({F{1'b0}}),
            .d   (f_su_reg),
            .q   (rq[i])
        );
    end

    tndf_delay #(
        .W     ($bits(tndf_pkg::side_f_t)),
        .DEPTH (F)
    ) u_side_f (
        .clk   (clk),
        .rst_n (rst_n),
        .din   (f_side_reg),
        .dout  (side_f_out)
    );

    // ------------------------------------------------------------------
    // g = E*sin2, force = g*m, saturate, zero on error
    // ------------------------------------------------------------------
    logic [F:0]          sin2;
    logic [F:0]          mq [3];
    logic                g1_valid_reg, g2_valid_reg, g3_valid_reg, done_reg;
    logic [1:0]          g1_err_reg, g2_err_reg, g3_err_reg;
    logic [F+31:0]       g1_prod_reg;
    logic signed [F+1:0] g1_m_reg [3];
    logic signed [F+1:0] g2_m_reg [3];
    logic [30:0]         g2_g_reg;
    logic signed [F+33:0] g3_f_reg [3];
    tndf_pkg::drag_out_t result_reg;
    logic signed [31:0]  force_sat [3];

    assign sin2 = side_f_out.sat[0] ? ONE_Q : {1'b0, rq[0]};

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            mq[i] = side_f_out.sat[i+1] ? ONE_Q : {1'b0, rq[i+1]};
            if (g3_err_reg != tndf_pkg::ERR_OK)
                force_sat[i] = '0;
            else
                force_sat[i] = tndf_pkg::sat32(tndf_pkg::rnd_signed(64'(g3_f_reg[i]), F));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            g1_valid_reg <= 1'b0;
            g2_valid_reg <= 1'b0;
            g3_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            g1_valid_reg <= side_f_out.valid;
            g2_valid_reg <= g1_valid_reg;
            g3_valid_reg <= g2_valid_reg;
            done_reg     <= g3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        g1_prod_reg <= side_f_out.e * sin2;
        for (int i = 0; i < 3; i++)
        begin
            g1_m_reg[i] <= side_f_out.nneg[i] ? -$signed({1'b0, mq[i]})
                                              : $signed({1'b0, mq[i]});
            g2_m_reg[i] <= g1_m_reg[i];
            g3_f_reg[i] <= $signed({1'b0, g2_g_reg}) * g2_m_reg[i];
        end
        g1_err_reg <= side_f_out.err;
        g2_g_reg   <= tndf_pkg::rnd_uclamp(64'(g1_prod_reg), F);
        g2_err_reg <= g1_err_reg;
        g3_err_reg <= g2_err_reg;
        result_reg.normal_force_x <= force_sat[0];
        result_reg.normal_force_y <= force_sat[1];
        result_reg.normal_force_z <= force_sat[2];
        result_reg.error_code     <= g3_err_reg;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule
